// File: src/pisc_pkg.sv
// Package of types and constants shared by the PI speed controller.
`timescale 1ns / 1ps

package pisc_pkg;

    localparam int SPEED_W  = 16;
    localparam int GAIN_W   = 16;
    localparam int DUTY_W   = 16;
    localparam int STATE_W  = 2;
    localparam int MODE_W   = 2;
    localparam int CFG_AW   = 3;
    localparam int CFG_DW   = 16;
    localparam int FRAC_W   = 12;
    localparam int INTEG_W  = 19;
    localparam int ERR_W    = SPEED_W + 1;
    localparam int PROD_W   = GAIN_W + 1 + ERR_W;
    localparam int SUM_W    = PROD_W + 1;
    localparam int FLOOR_W  = SUM_W - 1 - FRAC_W;

    localparam logic signed [INTEG_W-1:0] INTEG_LIMIT = 19'sd204800;

    localparam logic [GAIN_W-1:0] KP_RESET        = 16'd2048;
    localparam logic [GAIN_W-1:0] KI_RESET        = 16'd205;
    localparam logic [SPEED_W-1:0] ERR_LIMIT_RESET = 16'd50;
    localparam logic [DUTY_W-1:0] MAX_DUTY_RESET  = 16'd100;
    localparam logic [DUTY_W-1:0] MIN_DUTY_RESET  = 16'd20;

    typedef enum logic [MODE_W-1:0] {
        MODE_SAMPLE = 2'd0,
        MODE_TARGET = 2'd1,
        MODE_CLEAR  = 2'd2
    } mode_t;

    typedef enum logic [CFG_AW-1:0] {
        CFG_KP_GAIN     = 3'd0,
        CFG_KI_GAIN     = 3'd1,
        CFG_ERROR_LIMIT = 3'd2,
        CFG_MAX_DUTY    = 3'd3,
        CFG_MIN_DUTY    = 3'd4
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_ERR  = 3'b100
    } run_state_t;

    localparam logic [STATE_W-1:0] CODE_IDLE = 2'd0;
    localparam logic [STATE_W-1:0] CODE_RUN  = 2'd1;
    localparam logic [STATE_W-1:0] CODE_ERR  = 2'd2;

    function automatic logic [STATE_W-1:0] state_code(input run_state_t st);
        logic [STATE_W-1:0] code;
        case (st)
            ST_IDLE: code = CODE_IDLE;
            ST_RUN:  code = CODE_RUN;
            ST_ERR:  code = CODE_ERR;
            default: code = CODE_IDLE;
        endcase
        return code;
    endfunction

endpackage

// File: src/pi_speed_controller.sv
// PI motor speed regulator with integral anti-windup, top level.
// An input transfer reaches the result through the input register, then the result register.
// Throughput: one item per cycle while the output is not stalled; the PI update of the state is combinational.
// Reset: asynchronous, active low; gains and limits take their defaults,
// target and integral clear, the controller starts idle.
`timescale 1ns / 1ps

module pi_speed_controller (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [pisc_pkg::CFG_AW-1:0]   cfg_addr,
    input  logic [pisc_pkg::CFG_DW-1:0]   cfg_data,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [15:0]                   s_axis_tdata,  // [15:0] speed
    input  logic [1:0]                    s_axis_tuser,  // [1:0] mode
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [23:0]                   m_axis_tdata   // [15:0] duty, [17:16] ctrl_state
);
    import pisc_pkg::*;

    logic [GAIN_W-1:0]  kp_reg;
    logic [GAIN_W-1:0]  ki_reg;
    logic [SPEED_W-1:0] err_limit_reg;
    logic [DUTY_W-1:0]  max_duty_reg;
    logic [DUTY_W-1:0]  min_duty_reg;

    logic               in_valid_reg;
    logic [MODE_W-1:0]  in_mode_reg;
    logic [SPEED_W-1:0] in_speed_reg;

    logic                       out_valid_reg;
    logic [DUTY_W-1:0]          out_duty_reg;
    logic [STATE_W-1:0]         out_state_reg;

    logic [SPEED_W-1:0]         target_reg;
    logic signed [INTEG_W-1:0]  integ_reg;
    run_state_t                 run_state_reg;

    logic [SPEED_W-1:0]         target_next;
    logic signed [INTEG_W-1:0]  integ_next;
    run_state_t                 run_state_next;
    logic [DUTY_W-1:0]          duty_next;

    logic                       advance;
    logic signed [ERR_W-1:0]    err;
    logic signed [PROD_W-1:0]   ki_prod;
    logic signed [PROD_W-1:0]   kp_prod;
    logic signed [SUM_W-1:0]    acc_sum;
    logic signed [INTEG_W-1:0]  acc_clamped;
    logic signed [SUM_W-1:0]    duty_sum;
    logic [FLOOR_W-1:0]         floored;
    logic [FLOOR_W-1:0]         shaped;
    logic [DUTY_W-1:0]          sample_duty;
    logic                       err_high;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, out_state_reg, out_duty_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg        <= KP_RESET;
            ki_reg        <= KI_RESET;
            err_limit_reg <= ERR_LIMIT_RESET;
            max_duty_reg  <= MAX_DUTY_RESET;
            min_duty_reg  <= MIN_DUTY_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_KP_GAIN:     kp_reg        <= cfg_data;
                CFG_KI_GAIN:     ki_reg        <= cfg_data;
                CFG_ERROR_LIMIT: err_limit_reg <= cfg_data;
                CFG_MAX_DUTY:    max_duty_reg  <= cfg_data;
                CFG_MIN_DUTY:    min_duty_reg  <= cfg_data;
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        err         = $signed({1'b0, target_reg}) - $signed({1'b0, in_speed_reg});
        ki_prod     = $signed({1'b0, ki_reg}) * err;
        kp_prod     = $signed({1'b0, kp_reg}) * err;
        acc_sum     = {ki_prod[PROD_W-1], ki_prod}
                    + {{(SUM_W-INTEG_W){integ_reg[INTEG_W-1]}}, integ_reg};
        if (acc_sum > $signed({{(SUM_W-INTEG_W){1'b0}}, INTEG_LIMIT}))
            acc_clamped = INTEG_LIMIT;
        else if (acc_sum < -$signed({{(SUM_W-INTEG_W){1'b0}}, INTEG_LIMIT}))
            acc_clamped = -INTEG_LIMIT;
        else
            acc_clamped = acc_sum[INTEG_W-1:0];
        duty_sum    = {kp_prod[PROD_W-1], kp_prod}
                    + {{(SUM_W-INTEG_W){acc_clamped[INTEG_W-1]}}, acc_clamped};
        if (!duty_sum[SUM_W-1] && (duty_sum != '0))
            floored = duty_sum[SUM_W-2:FRAC_W];
        else
            floored = '0;
        if ((floored != '0) && (floored < {{(FLOOR_W-DUTY_W){1'b0}}, min_duty_reg}))
            shaped = {{(FLOOR_W-DUTY_W){1'b0}}, min_duty_reg};
        else
            shaped = floored;
        if (shaped > {{(FLOOR_W-DUTY_W){1'b0}}, max_duty_reg})
            sample_duty = max_duty_reg;
        else
            sample_duty = shaped[DUTY_W-1:0];
        err_high    = !err[ERR_W-1] && ({1'b0, err[SPEED_W-1:0]} > {err_limit_reg, 1'b0});
    end

    always_comb
    begin
        target_next    = target_reg;
        integ_next     = integ_reg;
        run_state_next = run_state_reg;
        duty_next      = '0;
        case (in_mode_reg)
            MODE_SAMPLE:
            begin
                if (run_state_reg != ST_IDLE)
                begin
                    integ_next = acc_clamped;
                    duty_next  = sample_duty;
                    if (err_high)
                        run_state_next = ST_ERR;
                end
            end
            MODE_TARGET:
            begin
                target_next    = in_speed_reg;
                integ_next     = '0;
                run_state_next = (in_speed_reg == '0) ? ST_IDLE : ST_RUN;
            end
            MODE_CLEAR:
            begin
                integ_next = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            target_reg    <= '0;
            integ_reg     <= '0;
            run_state_reg <= ST_IDLE;
        end
        else
        begin
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                target_reg    <= target_next;
                integ_reg     <= integ_next;
                run_state_reg <= run_state_next;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_mode_reg  <= s_axis_tuser;
            in_speed_reg <= s_axis_tdata;
        end
        if (advance)
        begin
            out_duty_reg  <= duty_next;
            out_state_reg <= state_code(run_state_next);
        end
    end

`ifndef SYNTHESIS
    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(run_state_reg))
        else $error("run state not one-hot");

    a_integ_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (integ_reg <= INTEG_LIMIT) && (integ_reg >= -INTEG_LIMIT))
        else $error("integral outside anti-windup limit");

    a_idle_zero_target: assert property (@(posedge clk) disable iff (!rst_n)
        (run_state_reg == ST_IDLE) == (target_reg == '0))
        else $error("idle state and target speed disagree");

    a_idle_no_duty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_state_reg == CODE_IDLE)) |-> (out_duty_reg == '0))
        else $error("nonzero duty reported while idle");
`endif

endmodule

// File: tb/sv/pi_speed_controller_tb.sv
// Self-checking testbench for the PI speed controller: directed and random streams.
`timescale 1ns / 1ps

module pi_speed_controller_tb;

    import pisc_pkg::*;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int N_PROBES     = 23;
    localparam int N_PHASES     = 5;
    localparam int ITEMS_PER_PH = 106;
    localparam int HOLD_AT      = 120;
    localparam int HOLD_CYCLES  = 300;

    typedef struct packed {
        logic [DUTY_W-1:0]  duty;
        logic [STATE_W-1:0] state;
    } result_t;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [SPEED_W-1:0] speed;
        bit                 pinned;
        result_t            want;
    } probe_row_t;

    localparam result_t NO_PIN = '0;

    localparam probe_row_t PROBES [0:N_PROBES-1] = '{
        '{MODE_SAMPLE, 16'd0,     1'b1, '{16'd0,   CODE_IDLE}},
        '{MODE_UNUSED, 16'hFFFF,  1'b1, '{16'd0,   CODE_IDLE}},
        '{MODE_CLEAR,  16'd0,     1'b1, '{16'd0,   CODE_IDLE}},
        '{MODE_TARGET, 16'd1000,  1'b1, '{16'd0,   CODE_RUN}},
        '{MODE_SAMPLE, 16'd1000,  1'b1, '{16'd0,   CODE_RUN}},
        '{MODE_SAMPLE, 16'd999,   1'b0, NO_PIN},
        '{MODE_SAMPLE, 16'd990,   1'b0, NO_PIN},
        '{MODE_SAMPLE, 16'd900,   1'b0, NO_PIN},
        '{MODE_SAMPLE, 16'd899,   1'b0, NO_PIN},
        '{MODE_SAMPLE, 16'd0,     1'b1, '{16'd100, CODE_ERR}},
        '{MODE_SAMPLE, 16'd1000,  1'b0, NO_PIN},
        '{MODE_SAMPLE, 16'hFFFF,  1'b0, NO_PIN},
        '{MODE_CLEAR,  16'd0,     1'b1, '{16'd0,   CODE_ERR}},
        '{MODE_UNUSED, 16'd1234,  1'b1, '{16'd0,   CODE_ERR}},
        '{MODE_TARGET, 16'd0,     1'b1, '{16'd0,   CODE_IDLE}},
        '{MODE_SAMPLE, 16'hFFFF,  1'b1, '{16'd0,   CODE_IDLE}},
        '{MODE_TARGET, 16'hFFFF,  1'b1, '{16'd0,   CODE_RUN}},
        '{MODE_SAMPLE, 16'hFFFF,  1'b1, '{16'd0,   CODE_RUN}},
        '{MODE_SAMPLE, 16'd0,     1'b1, '{16'd100, CODE_ERR}},
        '{MODE_TARGET, 16'd1,     1'b1, '{16'd0,   CODE_RUN}},
        '{MODE_SAMPLE, 16'd2,     1'b0, NO_PIN},
        '{MODE_SAMPLE, 16'h5555,  1'b0, NO_PIN},
        '{MODE_SAMPLE, 16'hAAAA,  1'b0, NO_PIN}
    };

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_we = 1'b0;
    logic [CFG_AW-1:0]   cfg_addr = '0;
    logic [CFG_DW-1:0]   cfg_data = '0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [15:0]         s_axis_tdata = '0;   // [15:0] speed
    logic [1:0]          s_axis_tuser = '0;   // [1:0] mode
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [23:0]         m_axis_tdata;        // [15:0] duty, [17:16] ctrl_state

    // regulator copy
    logic [GAIN_W-1:0]   kp_q12;
    logic [GAIN_W-1:0]   ki_q12;
    logic [SPEED_W-1:0]  err_lim;
    logic [DUTY_W-1:0]   duty_max;
    logic [DUTY_W-1:0]   duty_min;
    logic [SPEED_W-1:0]  tgt_speed;
    longint              integ_q12;
    logic [STATE_W-1:0]  ctl_code;

    result_t             pending_results [$];
    result_t             got_res;
    result_t             want_res;
    int                  fail_count = 0;
    int                  items_sent = 0;
    int                  results_seen = 0;
    int                  err_results = 0;
    int                  driven_results = 0;
    bit                  no_idle = 1'b0;
    bit                  hold_done;
    int                  stall_left;

    pi_speed_controller dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 clk = ~clk;

    function automatic int pick_gap();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(20, 60);
        return $urandom_range(1, 3);
    endfunction

    function automatic result_t regulate(input logic [MODE_W-1:0] mode,
                                         input logic [SPEED_W-1:0] speed);
        longint  err;
        longint  acc;
        longint  sum;
        longint  duty;
        result_t res;
        duty = 0;
        case (mode)
            MODE_SAMPLE:
            begin
                if (ctl_code != CODE_IDLE)
                begin
                    err = longint'(tgt_speed) - longint'(speed);
                    acc = integ_q12 + longint'(ki_q12) * err;
                    if (acc > longint'(INTEG_LIMIT))
                        acc = longint'(INTEG_LIMIT);
                    else if (acc < -longint'(INTEG_LIMIT))
                        acc = -longint'(INTEG_LIMIT);
                    integ_q12 = acc;
                    sum = longint'(kp_q12) * err + acc;
                    if (sum > 0)
                    begin
                        duty = sum >>> FRAC_W;
                        if (duty > 0 && duty < longint'(duty_min))
                            duty = longint'(duty_min);
                    end
                    if (duty > longint'(duty_max))
                        duty = longint'(duty_max);
                    if (err > 2 * longint'(err_lim))
                        ctl_code = CODE_ERR;
                end
            end
            MODE_TARGET:
            begin
                tgt_speed = speed;
                integ_q12 = 0;
                ctl_code = (speed == 0) ? CODE_IDLE : CODE_RUN;
            end
            MODE_CLEAR:
                integ_q12 = 0;
            default:
                ;
        endcase
        res.duty = duty[DUTY_W-1:0];
        res.state = ctl_code;
        return res;
    endfunction

    task automatic offer(input logic [MODE_W-1:0] mode, input logic [SPEED_W-1:0] speed,
                         input bit pinned, input result_t pin_res);
        int      gap;
        result_t res;
        gap = 0;
        if (!no_idle && $urandom_range(0, 99) < 25)
            gap = pick_gap();
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= mode;
        s_axis_tdata <= speed;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        res = regulate(mode, speed);
        if (pinned)
            res = pin_res;
        pending_results.push_back(res);
        items_sent++;
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apply_gains(input logic [CFG_DW-1:0] kp, input logic [CFG_DW-1:0] ki,
                               input logic [CFG_DW-1:0] lim, input logic [CFG_DW-1:0] mx,
                               input logic [CFG_DW-1:0] mn);
        logic [CFG_DW-1:0] vals [5];
        cfg_index_t        regs [5];
        vals = '{kp, ki, lim, mx, mn};
        regs = '{CFG_KP_GAIN, CFG_KI_GAIN, CFG_ERROR_LIMIT, CFG_MAX_DUTY, CFG_MIN_DUTY};
        for (int i = 0; i < 5; i++)
        begin
            cfg_we <= 1'b1;
            cfg_addr <= regs[i];
            cfg_data <= vals[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        kp_q12 = kp;
        ki_q12 = ki;
        err_lim = lim;
        duty_max = mx;
        duty_min = mn;
    endtask

    // sink: random back-pressure, one long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall_left <= 0;
            hold_done <= 1'b0;
        end
        else if (stall_left != 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (!hold_done && results_seen >= HOLD_AT)
        begin
            m_axis_tready <= 1'b0;
            stall_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (!no_idle && $urandom_range(0, 99) < 15)
        begin
            m_axis_tready <= 1'b0;
            stall_left <= pick_gap() - 1;
        end
        else
            m_axis_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got_res.duty = m_axis_tdata[15:0];
            got_res.state = m_axis_tdata[17:16];
            if (pending_results.size() == 0)
            begin
                $display("%0t: result with nothing pending: duty %0d state %0d",
                         $time, got_res.duty, got_res.state);
                fail_count++;
            end
            else
            begin
                want_res = pending_results.pop_front();
                if (got_res.duty !== want_res.duty)
                begin
                    $display("%0t: duty mismatch: expected %0d, got %0d",
                             $time, want_res.duty, got_res.duty);
                    fail_count++;
                end
                if (got_res.state !== want_res.state)
                begin
                    $display("%0t: ctrl_state mismatch: expected %0d, got %0d",
                             $time, want_res.state, got_res.state);
                    fail_count++;
                end
            end
            results_seen++;
            if (got_res.state == CODE_ERR)
                err_results++;
            if (got_res.duty != 0)
                driven_results++;
        end
    end

    initial
    begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        logic [MODE_W-1:0]  mode;
        logic [SPEED_W-1:0] speed;
        int                 r;
        int                 s;

        kp_q12 = KP_RESET;
        ki_q12 = KI_RESET;
        err_lim = ERR_LIMIT_RESET;
        duty_max = MAX_DUTY_RESET;
        duty_min = MIN_DUTY_RESET;
        tgt_speed = '0;
        integ_q12 = 0;
        ctl_code = CODE_IDLE;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_PROBES; i++)
            offer(PROBES[i].mode, PROBES[i].speed, PROBES[i].pinned, PROBES[i].want);

        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            settle();
            no_idle = (ph == 2);
            case (ph)
                0: apply_gains(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                1: apply_gains(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
                2: apply_gains(KP_RESET, KI_RESET, ERR_LIMIT_RESET, MAX_DUTY_RESET,
                               MIN_DUTY_RESET);
                3: apply_gains(16'd8192, 16'd1024, 16'd300, 16'd40, 16'd60);
                default:
                begin
                    s = $urandom_range(50, 1000);
                    apply_gains(16'($urandom_range(0, 16384)), 16'($urandom_range(0, 4096)),
                                16'($urandom_range(0, 2000)), 16'(s),
                                16'($urandom_range(0, s)));
                end
            endcase
            for (int n = 0; n < ITEMS_PER_PH; n++)
            begin
                r = $urandom_range(0, 99);
                if (ctl_code == CODE_IDLE && r < 50)
                    r = 0;
                speed = 16'($urandom);
                if (r < 8)
                begin
                    mode = MODE_TARGET;
                    case ($urandom_range(0, 9))
                        0: speed = '0;
                        1: speed = '1;
                        2, 3: speed = 16'($urandom);
                        default: speed = 16'($urandom_range(1, 3000));
                    endcase
                end
                else if (r < 13)
                    mode = MODE_CLEAR;
                else if (r < 16)
                    mode = MODE_UNUSED;
                else
                begin
                    mode = MODE_SAMPLE;
                    case ($urandom_range(0, 4))
                        0: s = int'(speed);
                        1: s = int'(tgt_speed) + int'($urandom_range(0, 1200)) - 600;
                        default: s = int'(tgt_speed) + int'($urandom_range(0, 128)) - 64;
                    endcase
                    if (s < 0)
                        s = 0;
                    else if (s > 65535)
                        s = 65535;
                    speed = s[SPEED_W-1:0];
                end
                offer(mode, speed, 1'b0, NO_PIN);
            end
        end

        settle();
        repeat (10) @(posedge clk);
        $display("Sent %0d transfers over %0d gain settings; %0d results compared.",
                 items_sent, N_PHASES + 1, results_seen);
        $display("%0d results reported the error state, %0d carried a nonzero duty.",
                 err_results, driven_results);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// File: files.f
src/pisc_pkg.sv
src/pi_speed_controller.sv
tb/sv/pi_speed_controller_tb.sv
